// File: rtl/core/mismatch_position_list_update_assert.svh
// ----------------------------------------------------------------------------
// Mismatch position list update - assertion macros
// Implication checks on the rising clock edge, switched off by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef MISMATCH_POSITION_LIST_UPDATE_ASSERT_SVH
`define MISMATCH_POSITION_LIST_UPDATE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MPLU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define MPLU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MPLU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define MPLU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/core/mplu_pkg.sv
// ----------------------------------------------------------------------------
// Mismatch position list update - package
// Shared constants, register codes and the control word passed along cells.
// ----------------------------------------------------------------------------
`default_nettype none

package mplu_pkg;

	localparam int MAX_SLOTS_DEF    = 8;
	localparam int BITMAP_WIDTH_DEF = 64;

	localparam int SLOT_W   = 4;
	localparam int KMER_W   = 7;
	localparam int FIELD_W  = 64;

	localparam logic [SLOT_W-1:0] SLOT_COUNT_RST  = 4'd3;
	localparam logic [KMER_W-1:0] KMER_LENGTH_RST = 7'd32;

	localparam logic [7:0] FLAG_BYTE = 8'hFF;

	typedef enum logic {
		REG_SLOT_COUNT  = 1'b0,
		REG_KMER_LENGTH = 1'b1
	} mplu_reg_t;

	typedef struct packed {
		logic valid;
		logic rev;
		logic mode;
	} mplu_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/mplu_extract_cell.sv
// ----------------------------------------------------------------------------
// Mismatch position list update - extraction cell
// Takes the lowest set bit of the remaining bitmap, writes its position into
// one slot of the fresh list and hands the rest on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module mplu_extract_cell #(
	parameter int SLOT         = 0,
	parameter int MAX_SLOTS    = mplu_pkg::MAX_SLOTS_DEF,
	parameter int BITMAP_WIDTH = mplu_pkg::BITMAP_WIDTH_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire  [mplu_pkg::KMER_W-1:0]     kmer_len,
	input  wire  mplu_pkg::mplu_ctrl_t      in_ctrl,
	input  wire  [BITMAP_WIDTH-1:0]         in_bits,
	input  wire  [8*MAX_SLOTS-1:0]          in_fresh,
	input  wire  [8*MAX_SLOTS-1:0]          in_stored,
	output logic                            in_ready,
	output mplu_pkg::mplu_ctrl_t            out_ctrl,
	output logic [BITMAP_WIDTH-1:0]         out_bits,
	output logic [8*MAX_SLOTS-1:0]          out_fresh,
	output logic [8*MAX_SLOTS-1:0]          out_stored,
	input  wire                             out_ready
);

	localparam int LW = 8 * MAX_SLOTS;
	localparam int IW = $clog2(BITMAP_WIDTH);

	mplu_pkg::mplu_ctrl_t ctrl_s1;
	logic [BITMAP_WIDTH-1:0] bits_s1;
	logic [LW-1:0]           fresh_s1;
	logic [LW-1:0]           stored_s1;

	logic [BITMAP_WIDTH-1:0] lowest;
	logic [IW-1:0]           idx;
	logic [7:0]              pos;
	logic [BITMAP_WIDTH-1:0] bits_nx;
	logic [LW-1:0]           fresh_nx;

	assign in_ready = !ctrl_s1.valid || out_ready;

	// isolate the lowest set bit, then encode it
	always_comb begin
		lowest = in_bits & (~in_bits + BITMAP_WIDTH'(1));
		idx    = '0;
		for (int b = 0; b < BITMAP_WIDTH; b++) begin
			if (lowest[b]) begin
				idx = idx | IW'(b);
			end
		end
		if (in_ctrl.rev) begin
			pos = 8'(kmer_len) - 8'(idx);
		end else begin
			pos = 8'(idx) + 8'd1;
		end
		bits_nx  = in_bits & ~lowest;
		fresh_nx = in_fresh;
		if (|in_bits) begin
			fresh_nx[SLOT*8 +: 8] = pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (in_ready) begin
			ctrl_s1 <= in_ctrl;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_ctrl.valid) begin
			bits_s1   <= bits_nx;
			fresh_s1  <= fresh_nx;
			stored_s1 <= in_stored;
		end
	end

	assign out_ctrl   = ctrl_s1;
	assign out_bits   = bits_s1;
	assign out_fresh  = fresh_s1;
	assign out_stored = stored_s1;

endmodule

`default_nettype wire

// File: rtl/core/mplu_merge_cell.sv
// ----------------------------------------------------------------------------
// Mismatch position list update - merge cell
// One merge step: compares the heads of both lists, writes the smaller (an
// equal pair once) into its own result slot and shifts the used heads out.
// ----------------------------------------------------------------------------
`default_nettype none

module mplu_merge_cell #(
	parameter int SLOT      = 0,
	parameter int MAX_SLOTS = mplu_pkg::MAX_SLOTS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	input  wire  [8*MAX_SLOTS-1:0]  in_a,
	input  wire  [8*MAX_SLOTS-1:0]  in_b,
	input  wire  [8*MAX_SLOTS-1:0]  in_acc,
	output logic                    in_ready,
	output logic                    out_valid,
	output logic [8*MAX_SLOTS-1:0]  out_a,
	output logic [8*MAX_SLOTS-1:0]  out_b,
	output logic [8*MAX_SLOTS-1:0]  out_acc,
	input  wire                     out_ready
);

	localparam int LW = 8 * MAX_SLOTS;

	logic          valid_s1;
	logic [LW-1:0] a_s1;
	logic [LW-1:0] b_s1;
	logic [LW-1:0] acc_s1;

	logic [7:0]    head_a;
	logic [7:0]    head_b;
	logic          take_a;
	logic          take_b;
	logic [LW-1:0] a_nx;
	logic [LW-1:0] b_nx;
	logic [LW-1:0] acc_nx;

	assign in_ready = !valid_s1 || out_ready;

	// a zero head marks an empty list; nothing is written when both are empty
	always_comb begin
		head_a = in_a[7:0];
		head_b = in_b[7:0];
		take_a = (head_a != 8'd0) && ((head_b == 8'd0) || (head_a <= head_b));
		take_b = (head_b != 8'd0) && ((head_a == 8'd0) || (head_b <= head_a));
		a_nx   = take_a ? (in_a >> 8) : in_a;
		b_nx   = take_b ? (in_b >> 8) : in_b;
		acc_nx = in_acc;
		if (take_a) begin
			acc_nx[SLOT*8 +: 8] = head_a;
		end else if (take_b) begin
			acc_nx[SLOT*8 +: 8] = head_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			a_s1   <= a_nx;
			b_s1   <= b_nx;
			acc_s1 <= acc_nx;
		end
	end

	assign out_valid = valid_s1;
	assign out_a     = a_s1;
	assign out_b     = b_s1;
	assign out_acc   = acc_s1;

endmodule

`default_nettype wire

// File: rtl/core/mismatch_position_list_update.sv
// ----------------------------------------------------------------------------
// Mismatch position list update - top level
// Turns a mismatch bitmap into a list of 1-based positions and either
// replaces or merges a stored position list with it.
// ----------------------------------------------------------------------------
// Use:
//  - Input items arrive on s_tvalid/s_tready: the bitmap and the stored list
//    in s_tdata, the mode and reverse flags in s_tuser. Results leave on
//    m_tvalid/m_tready: the new list in m_tdata, the overflow flag in m_tuser.
//  - slot_count and kmer_length sit on the APB port; write them only while
//    no item is in flight.
//  - Between acceptance and m_tvalid an item passes an input register,
//    MAX_SLOTS extraction cells (one set bit each), a join stage,
//    MAX_SLOTS merge cells (one merge step each) and the output register.
//  - Throughput is one item per cycle while m_tready does not hold it back;
//    each cell works in front of its register; the handshake sets the rate.
//  - Each stage has its own valid bit and loads whenever it is empty or its
//    successor moves, so a stalled receiver only stops items once the chain
//    has filled up; bubbles are squeezed out.
//  - Reset clears all valid bits and sets slot_count to 3, kmer_length to 32.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mismatch_position_list_update_assert.svh"

module mismatch_position_list_update #(
	parameter int MAX_SLOTS    = mplu_pkg::MAX_SLOTS_DEF,
	parameter int BITMAP_WIDTH = mplu_pkg::BITMAP_WIDTH_DEF
) (
	input  wire          clk,
	input  wire          arst_n,

	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [2:0]   paddr,
	input  wire  [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,

	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [127:0] s_tdata,   // [63:0] hit_bitmap, [127:64] stored_list
	input  wire  [1:0]   s_tuser,   // [0] mode, [1] reversed

	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [63:0]  m_tdata,   // [63:0] new_list
	output logic [0:0]   m_tuser    // [0] overflowed
);

	localparam int LW = 8 * MAX_SLOTS;
	localparam int SW = mplu_pkg::SLOT_W;
	localparam int KW = mplu_pkg::KMER_W;

	// ---------------- configuration ----------------
	logic [SW-1:0] slot_count_q;
	logic [KW-1:0] kmer_length_q;
	logic [SW-1:0] n_used;
	logic [KW-1:0] kmer_len;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q  <= mplu_pkg::SLOT_COUNT_RST;
			kmer_length_q <= mplu_pkg::KMER_LENGTH_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (mplu_pkg::mplu_reg_t'(paddr[2]))
				mplu_pkg::REG_SLOT_COUNT:  slot_count_q  <= pwdata[SW-1:0];
				mplu_pkg::REG_KMER_LENGTH: kmer_length_q <= pwdata[KW-1:0];
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (mplu_pkg::mplu_reg_t'(paddr[2]))
				mplu_pkg::REG_SLOT_COUNT:  prdata = 32'(slot_count_q);
				mplu_pkg::REG_KMER_LENGTH: prdata = 32'(kmer_length_q);
			endcase
		end
	end

	always_comb begin
		if (slot_count_q == '0) begin
			n_used = SW'(1);
		end else if (slot_count_q > SW'(MAX_SLOTS)) begin
			n_used = SW'(MAX_SLOTS);
		end else begin
			n_used = slot_count_q;
		end
		if (kmer_length_q > KW'(BITMAP_WIDTH)) begin
			kmer_len = KW'(BITMAP_WIDTH);
		end else begin
			kmer_len = kmer_length_q;
		end
	end

	// ---------------- input register ----------------
	mplu_pkg::mplu_ctrl_t    in_ctrl_s1;
	logic [BITMAP_WIDTH-1:0] in_bits_s1;
	logic [LW-1:0]           in_stored_s1;
	logic [BITMAP_WIDTH-1:0] hit_masked;

	mplu_pkg::mplu_ctrl_t    e_ctrl   [MAX_SLOTS+1];
	logic [BITMAP_WIDTH-1:0] e_bits   [MAX_SLOTS+1];
	logic [LW-1:0]           e_fresh  [MAX_SLOTS+1];
	logic [LW-1:0]           e_stored [MAX_SLOTS+1];
	logic                    e_ready  [MAX_SLOTS+1];

	// bits at or above the k-mer length are never scanned
	always_comb begin
		for (int i = 0; i < BITMAP_WIDTH; i++) begin
			hit_masked[i] = s_tdata[i] & (KW'(i) < kmer_len);
		end
	end

	assign s_tready = !in_ctrl_s1.valid || e_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ctrl_s1 <= '0;
		end else if (s_tready) begin
			in_ctrl_s1.valid <= s_tvalid;
			in_ctrl_s1.mode  <= s_tuser[0];
			in_ctrl_s1.rev   <= s_tuser[1];
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_bits_s1   <= hit_masked;
			in_stored_s1 <= s_tdata[64 +: LW];
		end
	end

	assign e_ctrl[0]   = in_ctrl_s1;
	assign e_bits[0]   = in_bits_s1;
	assign e_fresh[0]  = '0;
	assign e_stored[0] = in_stored_s1;

	// ---------------- extraction chain ----------------
	for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_extract
		mplu_extract_cell #(
			.SLOT         (k),
			.MAX_SLOTS    (MAX_SLOTS),
			.BITMAP_WIDTH (BITMAP_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.kmer_len   (kmer_len),
			.in_ctrl    (e_ctrl[k]),
			.in_bits    (e_bits[k]),
			.in_fresh   (e_fresh[k]),
			.in_stored  (e_stored[k]),
			.in_ready   (e_ready[k]),
			.out_ctrl   (e_ctrl[k+1]),
			.out_bits   (e_bits[k+1]),
			.out_fresh  (e_fresh[k+1]),
			.out_stored (e_stored[k+1]),
			.out_ready  (e_ready[k+1])
		);
	end

	// ---------------- join stage ----------------
	logic          mid_v_s2;
	logic [LW-1:0] mid_a_s2;
	logic [LW-1:0] mid_b_s2;
	logic [LW-1:0] mid_acc_s2;

	logic [7:0]    fresh_at_n;
	logic          fresh_ov;
	logic [LW-1:0] fresh_list;
	logic [LW-1:0] stored_trunc;
	logic [LW-1:0] stored_used;
	logic          run;
	logic          pass;
	logic [LW-1:0] mid_a_nx;
	logic [LW-1:0] mid_b_nx;
	logic [LW-1:0] mid_acc_nx;

	logic          mg_v   [MAX_SLOTS+1];
	logic [LW-1:0] mg_a   [MAX_SLOTS+1];
	logic [LW-1:0] mg_b   [MAX_SLOTS+1];
	logic [LW-1:0] mg_acc [MAX_SLOTS+1];
	logic          mg_rdy [MAX_SLOTS+1];

	// Overflow of the fresh list: more positions found than there are slots.
	// In merge mode a flagged stored list passes through; replace mode merges into nothing.
	always_comb begin
		fresh_at_n = 8'd0;
		for (int s = 0; s < MAX_SLOTS; s++) begin
			if (SW'(s) == n_used) begin
				fresh_at_n = e_fresh[MAX_SLOTS][s*8 +: 8];
			end
		end
		if (n_used < SW'(MAX_SLOTS)) begin
			fresh_ov = (fresh_at_n != 8'd0);
		end else begin
			fresh_ov = |e_bits[MAX_SLOTS];
		end
		run = 1'b1;
		for (int s = 0; s < MAX_SLOTS; s++) begin
			if (SW'(s) < n_used) begin
				fresh_list[s*8 +: 8]  = fresh_ov ? mplu_pkg::FLAG_BYTE
				                                 : e_fresh[MAX_SLOTS][s*8 +: 8];
				stored_used[s*8 +: 8] = e_stored[MAX_SLOTS][s*8 +: 8];
			end else begin
				fresh_list[s*8 +: 8]  = 8'd0;
				stored_used[s*8 +: 8] = 8'd0;
			end
			run = run & (stored_used[s*8 +: 8] != 8'd0);
			stored_trunc[s*8 +: 8] = run ? stored_used[s*8 +: 8] : 8'd0;
		end
		pass = e_ctrl[MAX_SLOTS].mode && (stored_used[7:0] == mplu_pkg::FLAG_BYTE);
		mid_a_nx   = (e_ctrl[MAX_SLOTS].mode && !pass) ? stored_trunc : '0;
		mid_b_nx   = pass ? '0 : fresh_list;
		mid_acc_nx = pass ? stored_used : '0;
	end

	assign e_ready[MAX_SLOTS] = !mid_v_s2 || mg_rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_v_s2 <= 1'b0;
		end else if (e_ready[MAX_SLOTS]) begin
			mid_v_s2 <= e_ctrl[MAX_SLOTS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (e_ready[MAX_SLOTS] && e_ctrl[MAX_SLOTS].valid) begin
			mid_a_s2   <= mid_a_nx;
			mid_b_s2   <= mid_b_nx;
			mid_acc_s2 <= mid_acc_nx;
		end
	end

	assign mg_v[0]   = mid_v_s2;
	assign mg_a[0]   = mid_a_s2;
	assign mg_b[0]   = mid_b_s2;
	assign mg_acc[0] = mid_acc_s2;

	// ---------------- merge chain ----------------
	for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_merge
		mplu_merge_cell #(
			.SLOT      (k),
			.MAX_SLOTS (MAX_SLOTS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (mg_v[k]),
			.in_a      (mg_a[k]),
			.in_b      (mg_b[k]),
			.in_acc    (mg_acc[k]),
			.in_ready  (mg_rdy[k]),
			.out_valid (mg_v[k+1]),
			.out_a     (mg_a[k+1]),
			.out_b     (mg_b[k+1]),
			.out_acc   (mg_acc[k+1]),
			.out_ready (mg_rdy[k+1])
		);
	end

	// ---------------- output register ----------------
	logic          out_v_s3;
	logic [LW-1:0] out_list_s3;
	logic          out_flag_s3;

	logic [7:0]    acc_at_n;
	logic          merge_ov;
	logic [LW-1:0] out_list_nx;
	logic          out_flag_nx;
	logic [63:0]   used_mask;

	// more merged entries than slots shows up as a write into slot n, or, with all slots used, as a head left over
	always_comb begin
		acc_at_n  = 8'd0;
		used_mask = '0;
		for (int s = 0; s < MAX_SLOTS; s++) begin
			if (SW'(s) == n_used) begin
				acc_at_n = mg_acc[MAX_SLOTS][s*8 +: 8];
			end
		end
		if (n_used < SW'(MAX_SLOTS)) begin
			merge_ov = (acc_at_n != 8'd0);
		end else begin
			merge_ov = (mg_a[MAX_SLOTS][7:0] != 8'd0) || (mg_b[MAX_SLOTS][7:0] != 8'd0);
		end
		out_flag_nx = 1'b1;
		for (int s = 0; s < MAX_SLOTS; s++) begin
			if (SW'(s) < n_used) begin
				out_list_nx[s*8 +: 8] = merge_ov ? mplu_pkg::FLAG_BYTE
				                                 : mg_acc[MAX_SLOTS][s*8 +: 8];
				out_flag_nx = out_flag_nx & (out_list_nx[s*8 +: 8] == mplu_pkg::FLAG_BYTE);
				used_mask[s*8 +: 8] = 8'hFF;
			end else begin
				out_list_nx[s*8 +: 8] = 8'd0;
			end
		end
	end

	assign mg_rdy[MAX_SLOTS] = !out_v_s3 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s3 <= 1'b0;
		end else if (mg_rdy[MAX_SLOTS]) begin
			out_v_s3 <= mg_v[MAX_SLOTS];
		end
	end

	always_ff @(posedge clk) begin
		if (mg_rdy[MAX_SLOTS] && mg_v[MAX_SLOTS]) begin
			out_list_s3 <= out_list_nx;
			out_flag_s3 <= out_flag_nx;
		end
	end

	assign m_tvalid   = out_v_s3;
	assign m_tdata    = 64'(out_list_s3);
	assign m_tuser[0] = out_flag_s3;

	// ---------------- checks ----------------
	`MPLU_ASSERT_IMPLY(a_ready_when_drained, clk, arst_n, !m_tvalid, s_tready, "input stalled with empty output register")
	`MPLU_ASSERT_NEXT(a_item_captured, clk, arst_n, s_tvalid && s_tready, in_ctrl_s1.valid, "accepted item not captured")
	`MPLU_ASSERT_IMPLY(a_flag_slot0, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[7:0] == mplu_pkg::FLAG_BYTE, "overflow flag without flagged slot 0")
	`MPLU_ASSERT_IMPLY(a_unused_slots_zero, clk, arst_n, m_tvalid, (m_tdata & ~used_mask) == 64'd0, "unused slots not zero")

endmodule

`default_nettype wire
